FILE: src/spj_pkg.sv
// ----------------------------------------------------------------------------
// spj_pkg
// shared types, codes and widths of the segment projection histogram
// ----------------------------------------------------------------------------
package spj_pkg;

   // default number of spectrum bins
   localparam int NUM_BINS_DEF = 1024;

   // operation codes of an input word
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // status codes of a result word
   localparam logic [2:0] ST_ADDED   = 3'd0;
   localparam logic [2:0] ST_OUTSIDE = 3'd1;
   localparam logic [2:0] ST_INVALID = 3'd2;
   localparam logic [2:0] ST_READ    = 3'd3;
   localparam logic [2:0] ST_CLEARED = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_AXIS_START  = 2'd0;
   localparam logic [1:0] CSR_BIN_WIDTH   = 2'd1;
   localparam logic [1:0] CSR_BINS_IN_USE = 2'd2;

   // arithmetic widths
   localparam int ACC_W   = 48;  // accumulator
   localparam int DIVN_W  = 59;  // signed dividend / quotient
   localparam int DIVD_W  = 50;  // unsigned divisor
   localparam int COORD_W = 50;  // bin coordinate, q.16 bins
   localparam int BIN_W   = 34;  // whole bin number
   localparam int CONTR_W = 43;  // contribution
   localparam int PART_W  = 17;  // share of one bin, q.16
   localparam logic [PART_W-1:0] PART_ONE = 17'd65536;

   // queue depths
   localparam int JOB_Q_DEPTH = 2;
   localparam int RSP_Q_DEPTH = 2;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] pos_a;
      logic signed [31:0] pos_b;
      logic signed [23:0] amp_a_re;
      logic signed [23:0] amp_b_re;
      logic signed [23:0] amp_a_im;
      logic signed [23:0] amp_b_im;
      logic [17:0]        seg_weight;
      logic               not_a_number;
      logic [9:0]         bin_index;
   } req_word_type;

   typedef struct packed {
      logic signed [47:0] bin_re;
      logic signed [47:0] bin_im;
      logic [2:0]         status;
      logic               saturated;
   } rsp_word_type;

   typedef enum logic [1:0] {
      JOB_ADD     = 2'd0,
      JOB_INVALID = 2'd1,
      JOB_READ    = 2'd2,
      JOB_CLEAR   = 2'd3
   } job_kind_type;

   typedef struct packed {
      job_kind_type       kind;
      logic signed [31:0] pos_lo;
      logic signed [31:0] pos_hi;
      logic signed [24:0] sum_re;
      logic signed [24:0] sum_im;
      logic [17:0]        weight;
      logic [9:0]         bin_index;
   } job_word_type;

   typedef struct packed {
      logic signed [31:0] axis_start;
      logic [30:0]        bin_width;
      logic [10:0]        bins_in_use;
   } cfg_type;

endpackage

FILE: src/spj_fifo.sv
// ----------------------------------------------------------------------------
// spj_fifo
// small first-in first-out queue of words
// ----------------------------------------------------------------------------
module spj_fifo #(
   parameter type T     = logic,
   parameter int  DEPTH = 2
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  T     push_word,
   output logic full,
   input  logic pop,
   output T     pop_word,
   output logic empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   T                 entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_word = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

FILE: src/spj_front.sv
// ----------------------------------------------------------------------------
// spj_front
// classifies an incoming word, orders the segment ends and pre-adds the amplitudes
// ----------------------------------------------------------------------------
module spj_front (
   input  spj_pkg::req_word_type req_word,
   output spj_pkg::job_word_type job_word
);

   always_comb begin
      job_word.kind = spj_pkg::JOB_READ;
      case (req_word.operation)
         spj_pkg::OP_ADD: begin
            job_word.kind = req_word.not_a_number ? spj_pkg::JOB_INVALID : spj_pkg::JOB_ADD;
         end
         spj_pkg::OP_CLEAR: begin
            job_word.kind = spj_pkg::JOB_CLEAR;
         end
         default: begin
            job_word.kind = spj_pkg::JOB_READ;
         end
      endcase

      // lower end first
      if (req_word.pos_a > req_word.pos_b) begin
         job_word.pos_lo = req_word.pos_b;
         job_word.pos_hi = req_word.pos_a;
      end else begin
         job_word.pos_lo = req_word.pos_a;
         job_word.pos_hi = req_word.pos_b;
      end

      job_word.sum_re    = 25'(req_word.amp_a_re) + 25'(req_word.amp_b_re);
      job_word.sum_im    = 25'(req_word.amp_a_im) + 25'(req_word.amp_b_im);
      job_word.weight    = req_word.seg_weight;
      job_word.bin_index = req_word.bin_index;
   end

endmodule

FILE: src/spj_div.sv
// ----------------------------------------------------------------------------
// spj_div
// shared restoring divider, one quotient bit a cycle, floor rounding
// ----------------------------------------------------------------------------
module spj_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [spj_pkg::DIVN_W-1:0] dividend,
   input  logic        [spj_pkg::DIVD_W-1:0] divisor,
   output logic                              done,
   output logic signed [spj_pkg::DIVN_W-1:0] quotient
);
   localparam int MAG_W = spj_pkg::DIVN_W - 1;
   localparam int DW    = spj_pkg::DIVD_W;
   localparam int CNT_W = $clog2(MAG_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [MAG_W-1:0] quo_ff, quo_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    den_ff, den_in;
   logic             neg_ff, neg_in;

   logic [DW:0]                       trial, trial_diff;
   logic                              fits, rem_nz;
   logic signed [spj_pkg::DIVN_W-1:0] qpos;

   assign trial      = {rem_ff, quo_ff[MAG_W-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign fits       = (trial >= {1'b0, den_ff});
   assign rem_nz     = (rem_ff != '0);
   assign qpos       = signed'({1'b0, quo_ff});
   assign done       = done_ff;
   // negative dividend: floor is one below the negated quotient when inexact
   assign quotient   = neg_ff ? (-qpos - spj_pkg::DIVN_W'(rem_nz)) : qpos;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
         neg_in  = dividend[spj_pkg::DIVN_W-1];
         quo_in  = dividend[spj_pkg::DIVN_W-1] ? MAG_W'(-dividend) : MAG_W'(dividend);
      end else if (busy_ff) begin
         rem_in = fits ? trial_diff[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[MAG_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

endmodule

FILE: src/spj_back.sv
// ----------------------------------------------------------------------------
// spj_back
// carries out jobs: bin coordinates, shares, spectrum update, reads, clears
// ----------------------------------------------------------------------------
module spj_back #(
   parameter int NUM_BINS = spj_pkg::NUM_BINS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  spj_pkg::cfg_type      cfg,
   input  logic                  job_empty,
   input  spj_pkg::job_word_type job_word,
   output logic                  job_pop,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output spj_pkg::rsp_word_type rsp_word,
   output logic                  init_busy
);
   localparam int IDX_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int CNT_W  = $clog2(NUM_BINS + 1);
   localparam int ACC_W  = spj_pkg::ACC_W;
   localparam int DIVN_W = spj_pkg::DIVN_W;
   localparam int DIVD_W = spj_pkg::DIVD_W;
   localparam int CRD_W  = spj_pkg::COORD_W;
   localparam int BIN_W  = spj_pkg::BIN_W;
   localparam int CON_W  = spj_pkg::CONTR_W;
   localparam int PART_W = spj_pkg::PART_W;

   typedef enum logic [17:0] {
      S_CLEAR      = 18'b000000000000000001,
      S_IDLE       = 18'b000000000000000010,
      S_READ       = 18'b000000000000000100,
      S_READ_DATA  = 18'b000000000000001000,
      S_L_SETUP    = 18'b000000000000010000,
      S_R_SETUP    = 18'b000000000000100000,
      S_C_SETUP    = 18'b000000000001000000,
      S_CIM_SETUP  = 18'b000000000010000000,
      S_PLAN       = 18'b000000000100000000,
      S_NEXT       = 18'b000000001000000000,
      S_SHARE_RE   = 18'b000000010000000000,
      S_SHARE_IM   = 18'b000000100000000000,
      S_SHARE_DONE = 18'b000001000000000000,
      S_RMW_RD     = 18'b000010000000000000,
      S_RMW_WR     = 18'b000100000000000000,
      S_DIV_GO     = 18'b001000000000000000,
      S_DIV_WAIT   = 18'b010000000000000000,
      S_RESULT     = 18'b100000000000000000
   } state_type;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_FIRST  = 3'd1,
      PH_LAST   = 3'd2,
      PH_MID    = 3'd3,
      PH_SINGLE = 3'd4
   } phase_type;

   function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] old,
                                              input logic signed [ACC_W-1:0] add);
      logic signed [ACC_W:0] s;
      logic [ACC_W:0]        r;
      s = (ACC_W + 1)'(old) + (ACC_W + 1)'(add);
      if (s[ACC_W] != s[ACC_W-1]) begin
         r = s[ACC_W] ? {1'b1, 1'b1, {(ACC_W - 1){1'b0}}} : {1'b1, 1'b0, {(ACC_W - 1){1'b1}}};
      end else begin
         r = {1'b0, s[ACC_W-1:0]};
      end
      return r;
   endfunction

   // control
   state_type        state_ff, state_in;
   state_type        ret_ff, ret_in;
   phase_type        phase_ff, phase_in;
   logic             init_ff, init_in;
   logic             clear_item_ff, clear_item_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   // payload
   spj_pkg::job_word_type     job_ff, job_in;
   spj_pkg::rsp_word_type     rsp_ff, rsp_in;
   logic                      sat_ff, sat_in;
   logic signed [DIVN_W-1:0]  div_num_ff, div_num_in;
   logic [DIVD_W-1:0]         div_den_ff, div_den_in;
   logic signed [DIVN_W-1:0]  div_q_ff, div_q_in;
   logic signed [CRD_W-1:0]   l_ff, l_in;
   logic signed [CRD_W-1:0]   r_ff, r_in;
   logic signed [BIN_W-1:0]   first_ff, first_in;
   logic signed [BIN_W-1:0]   last_ff, last_in;
   logic signed [CON_W-1:0]   c_re_ff, c_re_in;
   logic signed [CON_W-1:0]   c_im_ff, c_im_in;
   logic [DIVD_W-1:0]         span_ff, span_in;
   logic [PART_W-1:0]         part_ff, part_in;
   logic signed [ACC_W-1:0]   share_re_ff, share_re_in;
   logic signed [ACC_W-1:0]   share_im_ff, share_im_in;
   logic [IDX_W-1:0]          tgt_ff, tgt_in;
   logic [CNT_W-1:0]          k_ff, k_in;
   logic [CNT_W-1:0]          kstart_ff, kstart_in;
   logic [CNT_W-1:0]          kend_ff, kend_in;
   // spectrum store, real in the upper half
   logic [2*ACC_W-1:0]        mem [NUM_BINS];
   logic [2*ACC_W-1:0]        rdata_ff;
   logic                      mem_we;
   logic [IDX_W-1:0]          mem_waddr, mem_raddr;
   logic [2*ACC_W-1:0]        mem_wdata;

   logic                      div_start, div_done;
   logic signed [DIVN_W-1:0]  div_quot;
   logic [30:0]               w;
   logic [CNT_W-1:0]          n;
   logic signed [BIN_W-1:0]   n_s;
   logic signed [32:0]        diff_lo, diff_hi;
   logic signed [BIN_W-1:0]   first_c, last_c;
   logic                      outside_c, last_lt_n;
   logic signed [43:0]        wt_re, wt_im;
   logic signed [60:0]        part_re, part_im;
   logic [ACC_W:0]            upd_re, upd_im;
   logic [CNT_W-1:0]          k_next;
   logic [IDX_W-1:0]          rd_idx;
   logic                      rd_in_range;

   spj_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num_ff),
      .divisor  (div_den_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign w           = (cfg.bin_width == '0) ? 31'd1 : cfg.bin_width;
   assign n           = (32'(cfg.bins_in_use) < 32'(NUM_BINS)) ? CNT_W'(cfg.bins_in_use)
                                                                : CNT_W'(NUM_BINS);
   assign n_s         = signed'(BIN_W'(n));
   assign diff_lo     = 33'(job_ff.pos_lo) - 33'(cfg.axis_start);
   assign diff_hi     = 33'(job_ff.pos_hi) - 33'(cfg.axis_start);
   assign first_c     = signed'(l_ff[CRD_W-1:16]);
   assign last_c      = signed'(div_q_ff[CRD_W-1:16]);
   assign outside_c   = (first_c >= n_s) || last_c[BIN_W-1];
   assign last_lt_n   = (last_ff < n_s);
   assign wt_re       = job_ff.sum_re * signed'({1'b0, job_ff.weight});
   assign wt_im       = job_ff.sum_im * signed'({1'b0, job_ff.weight});
   assign part_re     = c_re_ff * signed'({1'b0, part_ff});
   assign part_im     = c_im_ff * signed'({1'b0, part_ff});
   assign upd_re      = sat_add(signed'(rdata_ff[2*ACC_W-1:ACC_W]), share_re_ff);
   assign upd_im      = sat_add(signed'(rdata_ff[ACC_W-1:0]), share_im_ff);
   assign k_next      = k_ff + CNT_W'(1);
   assign rd_idx      = IDX_W'(job_ff.bin_index);
   assign rd_in_range = (32'(job_ff.bin_index) < 32'(NUM_BINS));
   assign mem_raddr   = (state_ff == S_READ) ? rd_idx : tgt_ff;
   assign rsp_word    = rsp_ff;
   assign init_busy   = init_ff;

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      phase_in      = phase_ff;
      init_in       = init_ff;
      clear_item_in = clear_item_ff;
      sweep_in      = sweep_ff;
      job_in        = job_ff;
      rsp_in        = rsp_ff;
      sat_in        = sat_ff;
      div_num_in    = div_num_ff;
      div_den_in    = div_den_ff;
      div_q_in      = div_q_ff;
      l_in          = l_ff;
      r_in          = r_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      c_re_in       = c_re_ff;
      c_im_in       = c_im_ff;
      span_in       = span_ff;
      part_in       = part_ff;
      share_re_in   = share_re_ff;
      share_im_in   = share_im_ff;
      tgt_in        = tgt_ff;
      k_in          = k_ff;
      kstart_in     = kstart_ff;
      kend_in       = kend_ff;
      job_pop       = 1'b0;
      rsp_push      = 1'b0;
      div_start     = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = tgt_ff;
      mem_wdata     = {upd_re[ACC_W-1:0], upd_im[ACC_W-1:0]};

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '0;
            sweep_in  = sweep_ff + IDX_W'(1);
            if (sweep_ff == IDX_W'(NUM_BINS - 1)) begin
               sweep_in      = '0;
               init_in       = 1'b0;
               clear_item_in = 1'b0;
               if (clear_item_ff) begin
                  rsp_in.status = spj_pkg::ST_CLEARED;
                  state_in      = S_RESULT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (!job_empty && !rsp_full) begin
               job_pop = 1'b1;
               job_in  = job_word;
               sat_in  = 1'b0;
               rsp_in  = '0;
               case (job_word.kind)
                  spj_pkg::JOB_CLEAR: begin
                     clear_item_in = 1'b1;
                     state_in      = S_CLEAR;
                  end
                  spj_pkg::JOB_READ: begin
                     state_in = S_READ;
                  end
                  spj_pkg::JOB_INVALID: begin
                     rsp_in.status = spj_pkg::ST_INVALID;
                     state_in      = S_RESULT;
                  end
                  default: begin
                     state_in = S_L_SETUP;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_READ_DATA;
         end
         S_READ_DATA: begin
            if (rd_in_range) begin
               rsp_in.bin_re = signed'(rdata_ff[2*ACC_W-1:ACC_W]);
               rsp_in.bin_im = signed'(rdata_ff[ACC_W-1:0]);
            end
            rsp_in.status = spj_pkg::ST_READ;
            state_in      = S_RESULT;
         end
         S_L_SETUP: begin
            div_num_in = DIVN_W'(signed'({diff_lo, 16'h0000}));
            div_den_in = DIVD_W'(w);
            ret_in     = S_R_SETUP;
            state_in   = S_DIV_GO;
         end
         S_R_SETUP: begin
            l_in       = CRD_W'(div_q_ff);
            div_num_in = DIVN_W'(signed'({diff_hi, 16'h0000}));
            ret_in     = S_C_SETUP;
            state_in   = S_DIV_GO;
         end
         S_C_SETUP: begin
            r_in     = CRD_W'(div_q_ff);
            first_in = first_c;
            last_in  = last_c;
            if (outside_c) begin
               rsp_in.status = spj_pkg::ST_OUTSIDE;
               state_in      = S_RESULT;
            end else begin
               div_num_in = DIVN_W'(wt_re);
               div_den_in = DIVD_W'({w, 1'b0});
               ret_in     = S_CIM_SETUP;
               state_in   = S_DIV_GO;
            end
         end
         S_CIM_SETUP: begin
            c_re_in    = CON_W'(div_q_ff);
            div_num_in = DIVN_W'(wt_im);
            ret_in     = S_PLAN;
            state_in   = S_DIV_GO;
         end
         S_PLAN: begin
            c_im_in   = CON_W'(div_q_ff);
            span_in   = DIVD_W'(r_ff - l_ff);
            kstart_in = first_ff[BIN_W-1] ? '0 : CNT_W'(first_ff + BIN_W'(1));
            kend_in   = last_lt_n ? CNT_W'(last_ff) : n;
            if (first_ff == last_ff) begin
               share_re_in = ACC_W'(c_re_ff);
               share_im_in = ACC_W'(div_q_ff);
               tgt_in      = IDX_W'(first_ff);
               phase_in    = PH_SINGLE;
               state_in    = S_RMW_RD;
            end else begin
               phase_in = PH_START;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            // edge bins first, then the run of whole bins between them
            if ((phase_ff == PH_START) && !first_ff[BIN_W-1]) begin
               phase_in = PH_FIRST;
               part_in  = spj_pkg::PART_ONE - PART_W'(l_ff[15:0]);
               tgt_in   = IDX_W'(first_ff);
               state_in = S_SHARE_RE;
            end else if (((phase_ff == PH_START) || (phase_ff == PH_FIRST)) && last_lt_n) begin
               phase_in = PH_LAST;
               part_in  = PART_W'(r_ff[15:0]);
               tgt_in   = IDX_W'(last_ff);
               state_in = S_SHARE_RE;
            end else if ((phase_ff == PH_START) || (phase_ff == PH_FIRST) ||
                         (phase_ff == PH_LAST)) begin
               if (kstart_ff < kend_ff) begin
                  phase_in = PH_MID;
                  part_in  = spj_pkg::PART_ONE;
                  k_in     = kstart_ff;
                  tgt_in   = kstart_ff[IDX_W-1:0];
                  state_in = S_SHARE_RE;
               end else begin
                  rsp_in.status    = spj_pkg::ST_ADDED;
                  rsp_in.saturated = sat_ff;
                  state_in         = S_RESULT;
               end
            end else if ((phase_ff == PH_MID) && (k_next < kend_ff)) begin
               k_in     = k_next;
               tgt_in   = k_next[IDX_W-1:0];
               state_in = S_RMW_RD;
            end else begin
               rsp_in.status    = spj_pkg::ST_ADDED;
               rsp_in.saturated = sat_ff;
               state_in         = S_RESULT;
            end
         end
         S_SHARE_RE: begin
            div_num_in = DIVN_W'(part_re);
            div_den_in = span_ff;
            ret_in     = S_SHARE_IM;
            state_in   = S_DIV_GO;
         end
         S_SHARE_IM: begin
            share_re_in = ACC_W'(div_q_ff);
            div_num_in  = DIVN_W'(part_im);
            ret_in      = S_SHARE_DONE;
            state_in    = S_DIV_GO;
         end
         S_SHARE_DONE: begin
            share_im_in = ACC_W'(div_q_ff);
            state_in    = S_RMW_RD;
         end
         S_RMW_RD: begin
            state_in = S_RMW_WR;
         end
         S_RMW_WR: begin
            mem_we   = 1'b1;
            sat_in   = sat_ff | upd_re[ACC_W] | upd_im[ACC_W];
            state_in = S_NEXT;
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               div_q_in = div_quot;
               state_in = ret_ff;
            end
         end
         S_RESULT: begin
            rsp_push = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         ret_ff        <= S_IDLE;
         phase_ff      <= PH_START;
         init_ff       <= 1'b1;
         clear_item_ff <= 1'b0;
         sweep_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         phase_ff      <= phase_in;
         init_ff       <= init_in;
         clear_item_ff <= clear_item_in;
         sweep_ff      <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rsp_ff      <= rsp_in;
      sat_ff      <= sat_in;
      div_num_ff  <= div_num_in;
      div_den_ff  <= div_den_in;
      div_q_ff    <= div_q_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      c_re_ff     <= c_re_in;
      c_im_ff     <= c_im_in;
      span_ff     <= span_in;
      part_ff     <= part_in;
      share_re_ff <= share_re_in;
      share_im_ff <= share_im_in;
      tgt_ff      <= tgt_in;
      k_ff        <= k_in;
      kstart_ff   <= kstart_in;
      kend_ff     <= kend_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

endmodule

FILE: src/segment_projection_histogram.sv
// ----------------------------------------------------------------------------
// segment_projection_histogram
// accumulates segment contributions into a complex spectrum of fixed bins
// ----------------------------------------------------------------------------
// Each input word adds a segment, reads one bin or clears the spectrum, and
// yields exactly one result word. Words enter a short job queue and are
// worked one at a time by a sequencer around a single shared divider (58
// quotient steps) and a spectrum store with one read and one write port. An
// add takes two divisions for the bin coordinates and ends there if the
// segment lies wholly outside the grid; two more give both contribution
// components, and a segment that sits in one bin is then written. Otherwise
// each edge bin and the run of inner bins cost two more divisions each, and
// each bin written takes a read and a write of the store. After reset the
// store is swept to zero, during which full stays high; configuration writes
// are taken at any time and ready is always high.
// ----------------------------------------------------------------------------
module segment_projection_histogram #(
   parameter int NUM_BINS = spj_pkg::NUM_BINS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request side
   input  logic                  push,
   output logic                  full,
   input  spj_pkg::req_word_type req_word,
   // result side
   output logic                  empty,
   input  logic                  pop,
   output spj_pkg::rsp_word_type rsp_word,
   // configuration writes
   input  logic                  valid,
   output logic                  ready,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data
);

   // configuration registers
   logic signed [31:0]    axis_start_ff;
   logic [30:0]           bin_width_ff;
   logic [10:0]           bins_in_use_ff;
   spj_pkg::cfg_type      cfg;

   // front to back job queue
   spj_pkg::job_word_type job_in_word, job_out_word;
   logic                  job_full, job_empty, job_pop;

   // back to result queue
   spj_pkg::rsp_word_type rsp_in_word;
   logic                  rsp_full, rsp_push;
   logic                  init_busy;

   assign ready           = 1'b1;
   assign cfg.axis_start  = axis_start_ff;
   assign cfg.bin_width   = bin_width_ff;
   assign cfg.bins_in_use = bins_in_use_ff;

   // no word taken while the store is being swept after reset
   assign full = job_full | init_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_start_ff  <= '0;
         bin_width_ff   <= 31'd65536;
         bins_in_use_ff <= 11'd1024;
      end else if (valid && ready) begin
         case (csr_index)
            spj_pkg::CSR_AXIS_START:  axis_start_ff  <= signed'(csr_data);
            spj_pkg::CSR_BIN_WIDTH:   bin_width_ff   <= csr_data[30:0];
            spj_pkg::CSR_BINS_IN_USE: bins_in_use_ff <= csr_data[10:0];
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   // classify, order the ends, pre-add the amplitudes
   spj_front u_front (
      .req_word (req_word),
      .job_word (job_in_word)
   );

   spj_fifo #(
      .T     (spj_pkg::job_word_type),
      .DEPTH (spj_pkg::JOB_Q_DEPTH)
   ) u_job_q (
      .clock     (clock),
      .reset     (reset),
      .push      (push && !full),
      .push_word (job_in_word),
      .full      (job_full),
      .pop       (job_pop),
      .pop_word  (job_out_word),
      .empty     (job_empty)
   );

   // divider, spectrum store and bin walk
   spj_back #(
      .NUM_BINS (NUM_BINS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_empty (job_empty),
      .job_word  (job_out_word),
      .job_pop   (job_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_word  (rsp_in_word),
      .init_busy (init_busy)
   );

   // result words wait here until popped
   spj_fifo #(
      .T     (spj_pkg::rsp_word_type),
      .DEPTH (spj_pkg::RSP_Q_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_word (rsp_in_word),
      .full      (rsp_full),
      .pop       (pop),
      .pop_word  (rsp_word),
      .empty     (empty)
   );

endmodule

FILE: src/spj_checker.sv
// ----------------------------------------------------------------------------
// spj_checker
// port-level checks of the segment projection histogram
// ----------------------------------------------------------------------------
module spj_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  push,
   input logic                  full,
   input spj_pkg::req_word_type req_word,
   input logic                  empty,
   input logic                  pop,
   input spj_pkg::rsp_word_type rsp_word,
   input logic                  valid,
   input logic                  ready,
   input logic [1:0]            csr_index,
   input logic [31:0]           csr_data
);

   // store sweep after reset holds off input words
   a_reset_full: assert property (@(posedge clock) reset |=> full)
      else $error("full low right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_word))
      else $error("waiting result word changed");

   // only reads carry bin values
   a_zero_bins: assert property (@(posedge clock) disable iff (reset)
      !empty && (rsp_word.status != spj_pkg::ST_READ) |->
         (rsp_word.bin_re == 48'sd0) && (rsp_word.bin_im == 48'sd0))
      else $error("bin value on a non-read result");

   // only adds can clip
   a_sat_add: assert property (@(posedge clock) disable iff (reset)
      !empty && (rsp_word.status != spj_pkg::ST_ADDED) |-> !rsp_word.saturated)
      else $error("saturated flag on a non-add result");

endmodule

bind segment_projection_histogram spj_checker u_spj_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the segment projection histogram
// ----------------------------------------------------------------------------
// Words are pushed through the request queue with random gaps. The result
// queue is popped with random stalls. A bench-side projection of the spectrum
// predicts every result word at the moment its request word is accepted.
// Results are compared field by field against the oldest pending prediction.
// Several grid settings are visited, between drained phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int          N_BINS   = spj_pkg::NUM_BINS_DEF;
   localparam longint      ONE_BIN  = 65536;
   localparam longint      ACC_TOP  = 64'sd140737488355327;
   localparam longint      ACC_BOT  = -64'sd140737488355328;
   localparam int          DRAIN_CY = 3000;
   localparam logic [1:0]  OP_SPARE = 2'd3;   // fourth operation code

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push  = 1'b0;
   logic                  full;
   spj_pkg::req_word_type req_word = '0;
   logic                  empty;
   logic                  pop   = 1'b0;
   spj_pkg::rsp_word_type rsp_word;
   logic                  valid = 1'b0;
   logic                  ready;
   logic [1:0]            csr_index = spj_pkg::CSR_AXIS_START;
   logic [31:0]           csr_data  = '0;

   segment_projection_histogram #(.NUM_BINS(N_BINS)) DUT (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_word(req_word),
      .empty(empty), .pop(pop), .rsp_word(rsp_word),
      .valid(valid), .ready(ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   // bench copy of the grid settings and the spectrum
   longint       grid_axis;
   longint       grid_width;
   longint       grid_bins;
   longint       spec_re [N_BINS];
   longint       spec_im [N_BINS];
   bit           clip_seen;

   spj_pkg::rsp_word_type pending_rsp [$];
   int           err_count = 0;
   bit           quiet     = 1'b0;   // no idling on either side
   bit           hold_rsp  = 1'b0;   // long receiver hold-off

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #250ms;
      $display("tb_top: errors");
      $finish;
   end

   task automatic report_mismatch(input string what);
      err_count++;
      $display("tb_top: mismatch %s at %0t", what, $realtime);
   endtask

   // ---------------------------------------------------------------------
   // projection model
   // ---------------------------------------------------------------------
   function automatic longint floor_div(input longint a, input longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint clip_add(input longint a, input longint b);
      longint s;
      s = a + b;
      if (s > ACC_TOP) begin
         s = ACC_TOP;
         clip_seen = 1'b1;
      end
      if (s < ACC_BOT) begin
         s = ACC_BOT;
         clip_seen = 1'b1;
      end
      return s;
   endfunction

   function automatic void add_share(input longint idx, input longint cre,
                                     input longint cim, input longint part,
                                     input longint span);
      spec_re[idx] = clip_add(spec_re[idx], floor_div(cre * part, span));
      spec_im[idx] = clip_add(spec_im[idx], floor_div(cim * part, span));
   endfunction

   function automatic void reset_projection();
      grid_axis  = 0;
      grid_width = 65536;
      grid_bins  = 1024;
      foreach (spec_re[i]) begin
         spec_re[i] = 0;
         spec_im[i] = 0;
      end
   endfunction

   function automatic spj_pkg::rsp_word_type project(input spj_pkg::req_word_type w);
      spj_pkg::rsp_word_type r;
      longint wd, n, pa, pb, lc, rc, fb, lb, cre, cim, span, t;
      r = '0;
      clip_seen = 1'b0;
      if (w.operation == spj_pkg::OP_CLEAR) begin
         foreach (spec_re[i]) begin
            spec_re[i] = 0;
            spec_im[i] = 0;
         end
         r.status = spj_pkg::ST_CLEARED;
      end else if (w.operation != spj_pkg::OP_ADD) begin
         // the fourth code behaves as a read
         r.bin_re = spec_re[w.bin_index][47:0];
         r.bin_im = spec_im[w.bin_index][47:0];
         r.status = spj_pkg::ST_READ;
      end else if (w.not_a_number) begin
         r.status = spj_pkg::ST_INVALID;
      end else begin
         wd = (grid_width == 0) ? 1 : grid_width;
         n  = (grid_bins < N_BINS) ? grid_bins : N_BINS;
         pa = longint'($signed(w.pos_a));
         pb = longint'($signed(w.pos_b));
         if (pa > pb) begin
            t = pa; pa = pb; pb = t;
         end
         lc = floor_div((pa - grid_axis) * ONE_BIN, wd);
         rc = floor_div((pb - grid_axis) * ONE_BIN, wd);
         fb = floor_div(lc, ONE_BIN);
         lb = floor_div(rc, ONE_BIN);
         if (fb >= n || lb < 0) begin
            r.status = spj_pkg::ST_OUTSIDE;
         end else begin
            cre = floor_div((longint'($signed(w.amp_a_re)) + longint'($signed(w.amp_b_re)))
                            * longint'(w.seg_weight), 2 * wd);
            cim = floor_div((longint'($signed(w.amp_a_im)) + longint'($signed(w.amp_b_im)))
                            * longint'(w.seg_weight), 2 * wd);
            r.status = spj_pkg::ST_ADDED;
            if (fb == lb) begin
               spec_re[fb] = clip_add(spec_re[fb], cre);
               spec_im[fb] = clip_add(spec_im[fb], cim);
            end else begin
               span = rc - lc;
               if (fb >= 0) add_share(fb, cre, cim, (fb + 1) * ONE_BIN - lc, span);
               else fb = -1;
               if (lb < n) add_share(lb, cre, cim, rc - lb * ONE_BIN, span);
               else lb = n;
               for (longint k = fb + 1; k < lb; k++) add_share(k, cre, cim, ONE_BIN, span);
            end
         end
      end
      r.saturated = clip_seen;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // request side: one word per call, push left high for the next word
   // ---------------------------------------------------------------------
   task automatic send_word(input spj_pkg::req_word_type w);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      push     <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (full);
      pending_rsp.push_back(project(w));
   endtask

   task automatic drain();
      push <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CY) @(posedge clock);
   endtask

   // register write while the block is idle
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      drain();
      valid     <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!ready);
      valid <= 1'b0;
      case (idx)
         spj_pkg::CSR_AXIS_START:  grid_axis  = longint'($signed(data));
         spj_pkg::CSR_BIN_WIDTH:   grid_width = longint'(data[30:0]);
         spj_pkg::CSR_BINS_IN_USE: grid_bins  = longint'(data[10:0]);
         default: ;
      endcase
   endtask

   task automatic set_grid(input logic [31:0] axis, input logic [31:0] wd,
                           input logic [31:0] nb);
      write_reg(spj_pkg::CSR_AXIS_START, axis);
      write_reg(spj_pkg::CSR_BIN_WIDTH, wd);
      write_reg(spj_pkg::CSR_BINS_IN_USE, nb);
   endtask

   // ---------------------------------------------------------------------
   // result side: random stall bursts, hold-off on request
   // ---------------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
         end
      end
   end

   // compare each accepted result with the oldest pending prediction
   always @(posedge clock) begin
      spj_pkg::rsp_word_type exp_w;
      if (!reset && pop && !empty) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("result word with nothing pending");
         end else begin
            exp_w = pending_rsp.pop_front();
            if (rsp_word.bin_re !== exp_w.bin_re) report_mismatch("bin_re");
            if (rsp_word.bin_im !== exp_w.bin_im) report_mismatch("bin_im");
            if (rsp_word.status !== exp_w.status) report_mismatch("status");
            if (rsp_word.saturated !== exp_w.saturated) report_mismatch("saturated");
         end
      end
   end

   // ---------------------------------------------------------------------
   // word builders
   // ---------------------------------------------------------------------
   function automatic spj_pkg::req_word_type add_word(input longint pa, input longint pb,
                                                      input int are, input int bre,
                                                      input int aim, input int bim,
                                                      input int wt, input bit nan);
      spj_pkg::req_word_type w;
      w = '0;
      w.operation    = spj_pkg::OP_ADD;
      w.pos_a        = pa[31:0];
      w.pos_b        = pb[31:0];
      w.amp_a_re     = are[23:0];
      w.amp_b_re     = bre[23:0];
      w.amp_a_im     = aim[23:0];
      w.amp_b_im     = bim[23:0];
      w.seg_weight   = wt[17:0];
      w.not_a_number = nan;
      w.bin_index    = 10'($urandom);
      return w;
   endfunction

   function automatic spj_pkg::req_word_type read_word(input int idx, input logic [1:0] op);
      spj_pkg::req_word_type w;
      w = spj_pkg::req_word_type'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom});
      w.operation = op;
      w.bin_index = idx[9:0];
      return w;
   endfunction

   function automatic int rand_amp();
      if ($urandom_range(0, 2) == 0) return $signed($urandom) >>> 8;
      return $urandom_range(0, 2000) - 1000;
   endfunction

   // reads, clears when allowed, and segments: mostly short ones on the active grid, some anywhere at all
   function automatic spj_pkg::req_word_type rand_word(input bit clears_ok);
      int     pick;
      longint wd, n, pa, pb, sb;
      pick = $urandom_range(0, 99);
      if (pick < 18) return read_word($urandom, spj_pkg::OP_READ);
      if (pick < 21) return read_word($urandom, OP_SPARE);
      if (pick < 23 && clears_ok) return read_word($urandom, spj_pkg::OP_CLEAR);
      wd = (grid_width == 0) ? 1 : grid_width;
      n  = (grid_bins == 0) ? 4 : ((grid_bins > N_BINS) ? N_BINS : grid_bins);
      if ($urandom_range(0, 9) == 0) begin
         pa = longint'($signed($urandom));
         pb = longint'($signed($urandom));
      end else begin
         sb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 2);
         pa = grid_axis + (longint'($urandom_range(0, n + 3)) - 2) * wd
              + longint'($urandom) % wd;
         pb = pa + sb * wd + longint'($urandom) % wd;
         if ($urandom_range(0, 1)) begin
            sb = pa; pa = pb; pb = sb;
         end
      end
      return add_word(pa, pb, rand_amp(), rand_amp(), rand_amp(), rand_amp(),
                      $urandom, ($urandom_range(0, 9) == 0));
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_reset_state();
      send_word(read_word(0, spj_pkg::OP_READ));
      send_word(read_word(1023, spj_pkg::OP_READ));
   endtask

   // extremes, every operation and each special case on the default grid
   task automatic test_directed();
      // single-bin segment, then the same bin read back
      send_word(add_word(3 * ONE_BIN + 5, 3 * ONE_BIN + 9, 100, 300, -50, 20, 65536, 0));
      send_word(read_word(3, spj_pkg::OP_READ));
      // edge shares and inner bins
      send_word(add_word(2 * ONE_BIN + 16384, 6 * ONE_BIN + 100, 8388607, 8388607,
                         -8388608, -8388608, 262143, 0));
      send_word(read_word(2, spj_pkg::OP_READ));
      send_word(read_word(4, OP_SPARE));
      send_word(read_word(6, spj_pkg::OP_READ));
      // end positions swapped
      send_word(add_word(9 * ONE_BIN, 7 * ONE_BIN + 1, -8388608, 8388607, 1, -1, 40000, 0));
      // invalid mark wins over outside
      send_word(add_word(-5 * ONE_BIN, -4 * ONE_BIN, 10, 10, 10, 10, 65536, 1));
      // wholly left and wholly right of the grid
      send_word(add_word(-5 * ONE_BIN, -1, 10, 10, 10, 10, 65536, 0));
      send_word(add_word(1024 * ONE_BIN, 64'sh7fffffff, 10, 10, 10, 10, 65536, 0));
      // chopped at both grid ends, extreme positions
      send_word(add_word(-64'sh80000000, 64'sh7fffffff, 8388607, -8388608, 77, -77,
                         262143, 0));
      // zero weight still counts as added
      send_word(add_word(ONE_BIN, 2 * ONE_BIN, 500, 500, 500, 500, 0, 0));
      send_word(read_word(0, spj_pkg::OP_READ));
      send_word(read_word(1023, spj_pkg::OP_READ));
      send_word(read_word(512, spj_pkg::OP_READ));
      send_word(read_word(0, spj_pkg::OP_CLEAR));
      send_word(read_word(6, spj_pkg::OP_READ));
   endtask

   // unit bin width makes each add large enough to clip within a few dozen words
   task automatic test_saturation();
      set_grid(32'd0, 32'd1, 32'd16);
      for (int i = 0; i < 70; i++) begin
         send_word(add_word(5, 5, 8388607, 8388607, -8388608, -8388608, 262143, 0));
      end
      send_word(read_word(5, spj_pkg::OP_READ));
      send_word(read_word(0, spj_pkg::OP_CLEAR));
   endtask

   // receiver holds off while the sender keeps offering words
   task automatic test_back_pressure();
      hold_rsp = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join_none
      for (int i = 0; i < 12; i++) send_word(read_word($urandom, spj_pkg::OP_READ));
   endtask

   task automatic test_random_phase(input logic [31:0] axis, input logic [31:0] wd,
                                    input logic [31:0] nb, input int count);
      set_grid(axis, wd, nb);
      for (int i = 0; i < count; i++) send_word(rand_word(1'b1));
   endtask

   initial begin
      reset_projection();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_directed();
      test_saturation();
      test_back_pressure();

      test_random_phase(32'd0, 32'd65536, 32'd1024, 300);
      test_random_phase(-32'sd196608, 32'd32768, 32'd64, 250);
      test_random_phase(32'h7fffffff, 32'h7fffffff, 32'd2, 120);
      test_random_phase(32'h80000000, 32'hffffffff, 32'd1024, 120);
      test_random_phase(32'd12345, 32'h80000000, 32'd37, 150);   // width zero acts as one
      test_random_phase(32'd0, 32'd65536, 32'd0, 60);            // no bins at all
      test_random_phase(32'hfffe0000, 32'd100000, 32'd1, 100);
      test_random_phase(32'h00010000, 32'd20000, 32'hfffff7ff, 250);  // over the store size
      test_random_phase(-32'sd1000000, 32'd50000, 32'd300, 250);

      // last part without any idling
      drain();
      quiet = 1'b1;
      for (int i = 0; i < 200; i++) send_word(rand_word(1'b0));

      drain();
      if (err_count == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

endmodule

FILE: filelist.f
src/spj_pkg.sv
src/spj_fifo.sv
src/spj_front.sv
src/spj_div.sv
src/spj_back.sv
src/segment_projection_histogram.sv
src/spj_checker.sv
dv/tb_top.sv
